/* rtl/ssp_pkg.sv */
package ssp_pkg;

  // Pool sizing
  localparam int MaxEntities = 1024;
  localparam int Capacity    = 256;
  localparam int ValueWidth  = 32;

  // Fixed field widths of the request and response
  localparam int KindW   = 2;
  localparam int IdW     = 10;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 9;

  // Derived storage widths
  localparam int SparseAw = $clog2(MaxEntities);
  localparam int SlotW    = $clog2(Capacity);
  localparam int LinkW    = $clog2(Capacity + 1);

  typedef enum logic [KindW-1:0] {
    KindFind  = 2'd0,
    KindSet   = 2'd1,
    KindErase = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatRange = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SLink,
    SVal,
    SMove,
    SUnlink
  } state_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   entity_id;
    logic [DataW-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [DataW-1:0]   read_value;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  entry_count;
  } rsp_t;

  // Memory port commands from the sequencer
  typedef struct packed {
    logic                we;
    logic [SparseAw-1:0] waddr;
    logic [LinkW-1:0]    wdata;
    logic                re;
    logic [SparseAw-1:0] raddr;
  } sparse_cmd_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] waddr;
    logic [IdW-1:0]   wdata;
    logic             re;
    logic [SlotW-1:0] raddr;
  } entity_cmd_t;

  typedef struct packed {
    logic                  we;
    logic [SlotW-1:0]      waddr;
    logic [ValueWidth-1:0] wdata;
    logic                  re;
    logic [SlotW-1:0]      raddr;
  } value_cmd_t;

endpackage

/* rtl/ssp_ram.sv */
module ssp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ssp_ctrl.sv */
module ssp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ssp_pkg::req_t                 req_i,
  output logic                          done_o,
  output ssp_pkg::rsp_t                 rsp_o,
  output ssp_pkg::sparse_cmd_t          sparse_cmd_o,
  input  logic [ssp_pkg::LinkW-1:0]     sparse_rdata_i,
  output ssp_pkg::entity_cmd_t          entity_cmd_o,
  input  logic [ssp_pkg::IdW-1:0]       entity_rdata_i,
  output ssp_pkg::value_cmd_t           value_cmd_o,
  input  logic [ssp_pkg::ValueWidth-1:0] value_rdata_i
);
  import ssp_pkg::*;

  state_e               state_q, state_d;
  logic [SparseAw-1:0]  clr_q, clr_d;
  req_t                 req_q, req_d;
  logic [LinkW-1:0]     count_q, count_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 done_q, done_d;

  logic                 clr_last;
  logic                 id_ok;
  logic                 hit;
  logic                 full;
  logic [SlotW-1:0]     link_slot;
  logic [SlotW-1:0]     last_slot;
  logic [LinkW-1:0]     count_inc;
  logic [LinkW-1:0]     count_dec;
  logic                 moved_ok;

  // Link decode and pool bookkeeping
  assign clr_last  = (clr_q == SparseAw'(MaxEntities - 1));
  assign id_ok     = (32'(req_i.entity_id) < MaxEntities);
  assign hit       = (sparse_rdata_i != '0) && (sparse_rdata_i <= count_q) &&
                     (32'(sparse_rdata_i) <= Capacity);
  assign link_slot = SlotW'(sparse_rdata_i - LinkW'(1));
  assign last_slot = SlotW'(count_q - LinkW'(1));
  assign full      = (32'(count_q) >= Capacity);
  assign count_inc = count_q + LinkW'(1);
  assign count_dec = count_q - LinkW'(1);
  assign moved_ok  = (32'(entity_rdata_i) < MaxEntities);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SClear: begin
        if (clr_last) state_d = SIdle;
      end
      SIdle: begin
        if (start && id_ok) state_d = SLink;
      end
      SLink: begin
        state_d = SIdle;
        case (req_q.kind)
          KindFind: begin
            if (hit) state_d = SVal;
          end
          KindErase: begin
            if (hit && (link_slot != last_slot)) state_d = SMove;
          end
          default: state_d = SIdle;
        endcase
      end
      SVal:    state_d = SIdle;
      SMove:   state_d = SUnlink;
      SUnlink: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Memory commands, datapath updates and response
  always_comb begin
    clr_d        = clr_q;
    req_d        = req_q;
    count_d      = count_q;
    slot_d       = slot_q;
    rsp_d        = rsp_q;
    done_d       = 1'b0;
    sparse_cmd_o = '0;
    entity_cmd_o = '0;
    value_cmd_o  = '0;
    busy         = (state_q != SIdle);

    case (state_q)
      // Sweep the sparse table to zero after reset
      SClear: begin
        sparse_cmd_o.we    = 1'b1;
        sparse_cmd_o.waddr = clr_q;
        sparse_cmd_o.wdata = '0;
        clr_d              = clr_q + SparseAw'(1);
      end

      // Take a request and fetch its sparse link
      SIdle: begin
        if (start) begin
          req_d              = req_i;
          sparse_cmd_o.re    = 1'b1;
          sparse_cmd_o.raddr = SparseAw'(req_i.entity_id);
          if (!id_ok) begin
            rsp_d.found       = 1'b0;
            rsp_d.read_value  = '0;
            rsp_d.status      = StatRange;
            rsp_d.entry_count = CountW'(count_q);
            done_d            = 1'b1;
          end
        end
      end

      // Decide on the operation from the link
      SLink: begin
        slot_d            = link_slot;
        rsp_d.found       = hit;
        rsp_d.read_value  = '0;
        rsp_d.status      = StatOk;
        rsp_d.entry_count = CountW'(count_q);
        done_d            = 1'b1;
        case (req_q.kind)
          KindFind: begin
            if (hit) begin
              value_cmd_o.re    = 1'b1;
              value_cmd_o.raddr = link_slot;
              done_d            = 1'b0;
            end
          end
          KindSet: begin
            if (hit) begin
              value_cmd_o.we    = 1'b1;
              value_cmd_o.waddr = link_slot;
              value_cmd_o.wdata = ValueWidth'(req_q.write_value);
            end else if (full) begin
              rsp_d.status = StatFull;
            end else begin
              // Append at the dense end
              entity_cmd_o.we    = 1'b1;
              entity_cmd_o.waddr = SlotW'(count_q);
              entity_cmd_o.wdata = req_q.entity_id;
              value_cmd_o.we     = 1'b1;
              value_cmd_o.waddr  = SlotW'(count_q);
              value_cmd_o.wdata  = ValueWidth'(req_q.write_value);
              sparse_cmd_o.we    = 1'b1;
              sparse_cmd_o.waddr = SparseAw'(req_q.entity_id);
              sparse_cmd_o.wdata = count_inc;
              count_d            = count_inc;
              rsp_d.entry_count  = CountW'(count_inc);
            end
          end
          KindErase: begin
            if (hit) begin
              if (link_slot != last_slot) begin
                // Fetch the last entry to move into the hole
                entity_cmd_o.re    = 1'b1;
                entity_cmd_o.raddr = last_slot;
                value_cmd_o.re     = 1'b1;
                value_cmd_o.raddr  = last_slot;
                done_d             = 1'b0;
              end else begin
                sparse_cmd_o.we    = 1'b1;
                sparse_cmd_o.waddr = SparseAw'(req_q.entity_id);
                sparse_cmd_o.wdata = '0;
                count_d            = count_dec;
                rsp_d.entry_count  = CountW'(count_dec);
              end
            end
          end
          default: begin
            rsp_d.status = StatOk;
          end
        endcase
      end

      // Return the value of a find hit
      SVal: begin
        rsp_d.found       = 1'b1;
        rsp_d.read_value  = DataW'(value_rdata_i);
        rsp_d.status      = StatOk;
        rsp_d.entry_count = CountW'(count_q);
        done_d            = 1'b1;
      end

      // Move the last entry and relink it
      SMove: begin
        entity_cmd_o.we    = 1'b1;
        entity_cmd_o.waddr = slot_q;
        entity_cmd_o.wdata = entity_rdata_i;
        value_cmd_o.we     = 1'b1;
        value_cmd_o.waddr  = slot_q;
        value_cmd_o.wdata  = value_rdata_i;
        if (moved_ok) begin
          sparse_cmd_o.we    = 1'b1;
          sparse_cmd_o.waddr = SparseAw'(entity_rdata_i);
          sparse_cmd_o.wdata = LinkW'(slot_q) + LinkW'(1);
        end
      end

      // Drop the erased entity's link and shrink
      SUnlink: begin
        sparse_cmd_o.we    = 1'b1;
        sparse_cmd_o.waddr = SparseAw'(req_q.entity_id);
        sparse_cmd_o.wdata = '0;
        count_d            = count_dec;
        rsp_d.found        = 1'b1;
        rsp_d.read_value   = '0;
        rsp_d.status       = StatOk;
        rsp_d.entry_count  = CountW'(count_dec);
        done_d             = 1'b1;
      end

      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    slot_q <= slot_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/sparse_set_component_pool.sv */
// Channel   Direction  Handshake                    Payload
// request   in         start high while busy low    req_i  (kind, entity_id, write_value)
// response  out        done_o high for one cycle    rsp_o  (found, read_value, status,
//                                                           entry_count)
//
// Each request fetches its sparse link through the sparse table's registered read;
// the strobe is registered from the final state: SLink for set, find miss, plain
// erase and unused kinds, SVal after SLink for a find hit, and SUnlink after SLink
// and SMove for an erase that moves the last entry (the dense read and two sparse
// writes run one after another). An out-of-range id answers in the next cycle, and
// busy is low again as the strobe rises; responses cannot stall. After reset busy
// stays high while all MaxEntities (1024) sparse entries are zeroed, one per cycle.
module sparse_set_component_pool (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ssp_pkg::req_t req_i,
  output logic          done_o,
  output ssp_pkg::rsp_t rsp_o
);
  import ssp_pkg::*;

  sparse_cmd_t           sparse_cmd;
  entity_cmd_t           entity_cmd;
  value_cmd_t            value_cmd;
  logic [LinkW-1:0]      sparse_rdata;
  logic [IdW-1:0]        entity_rdata;
  logic [ValueWidth-1:0] value_rdata;

  // Sequencer
  ssp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .done_o         (done_o),
    .rsp_o          (rsp_o),
    .sparse_cmd_o   (sparse_cmd),
    .sparse_rdata_i (sparse_rdata),
    .entity_cmd_o   (entity_cmd),
    .entity_rdata_i (entity_rdata),
    .value_cmd_o    (value_cmd),
    .value_rdata_i  (value_rdata)
  );

  // Sparse table: entity id to dense slot plus one
  ssp_ram #(
    .Width (LinkW),
    .Depth (MaxEntities)
  ) u_sparse (
    .clk_i   (clk_i),
    .we_i    (sparse_cmd.we),
    .waddr_i (sparse_cmd.waddr),
    .wdata_i (sparse_cmd.wdata),
    .re_i    (sparse_cmd.re),
    .raddr_i (sparse_cmd.raddr),
    .rdata_o (sparse_rdata)
  );

  // Dense entity ids
  ssp_ram #(
    .Width (IdW),
    .Depth (Capacity)
  ) u_dense_entity (
    .clk_i   (clk_i),
    .we_i    (entity_cmd.we),
    .waddr_i (entity_cmd.waddr),
    .wdata_i (entity_cmd.wdata),
    .re_i    (entity_cmd.re),
    .raddr_i (entity_cmd.raddr),
    .rdata_o (entity_rdata)
  );

  // Dense component values
  ssp_ram #(
    .Width (ValueWidth),
    .Depth (Capacity)
  ) u_dense_value (
    .clk_i   (clk_i),
    .we_i    (value_cmd.we),
    .waddr_i (value_cmd.waddr),
    .wdata_i (value_cmd.wdata),
    .re_i    (value_cmd.re),
    .raddr_i (value_cmd.raddr),
    .rdata_o (value_rdata)
  );

endmodule
